FILE: rtl/cst_pkg.sv
// Shared types, constants and helper functions of the C source tokenizer.
`default_nettype none

package cst_pkg;

    localparam int CNT_BITS   = 16;
    localparam int KW_BYTES   = 8;
    localparam int KW_COUNT   = 29;
    localparam int OUT_W      = 16;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [KW_BYTES*8-1:0] t_word;

    typedef enum logic [3:0] {
        K_DIRECTIVE = 4'd0,
        K_LITERAL   = 4'd1,
        K_COMMENT   = 4'd2,
        K_OPERATOR  = 4'd3,
        K_PUNCT     = 4'd4,
        K_NUMBER    = 4'd5,
        K_IDENT     = 4'd6,
        K_KEYWORD   = 4'd7,
        K_IGNORE    = 4'd8,
        K_END       = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE,
        M_HOLD_SLASH,
        M_HOLD_QUOTE,
        M_LITERAL,
        M_COMMENT,
        M_IDENT,
        M_SPACE
    } t_mode;

    typedef struct packed {
        t_kind            kind;
        logic [OUT_W-1:0] line;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] len;
        logic             last;
    } t_rec;

    // Up to two records per source byte, in emission order.
    typedef struct packed {
        logic v0;
        t_rec r0;
        logic v1;
        t_rec r1;
    } t_lex_out;

    // Words are kept right-aligned, first byte highest, zero above.
    localparam t_word KW_TABLE [KW_COUNT] = '{
        t_word'("char"),   t_word'("short"),   t_word'("int"),    t_word'("long"),
        t_word'("unsigned"), t_word'("signed"), t_word'("float"), t_word'("double"),
        t_word'("bool"),   t_word'("_Bool"),   t_word'("struct"), t_word'("enum"),
        t_word'("union"),  t_word'("return"),  t_word'("while"),  t_word'("goto"),
        t_word'("if"),     t_word'("do"),      t_word'("for"),    t_word'("typedef"),
        t_word'("sizeof"), t_word'("main"),    t_word'("const"),  t_word'("volatile"),
        t_word'("extern"), t_word'("static"),  t_word'("auto"),   t_word'("void"),
        t_word'("else")
    };

    function automatic t_cnt sat_inc(t_cnt v);
        return (v == {CNT_BITS{1'b1}}) ? v : v + t_cnt'(1);
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(t_cnt v);
        logic [CNT_BITS+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        if (w > {{CNT_BITS{1'b0}}, {OUT_W{1'b1}}}) begin
            return {OUT_W{1'b1}};
        end
        return w[OUT_W-1:0];
    endfunction

    function automatic logic kw_match(t_word w, t_cnt n);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (w == KW_TABLE[i]) begin
                hit = 1'b1;
            end
        end
        return hit && (n <= t_cnt'(KW_BYTES));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cst_lexer.sv
// Lexer state and one-byte step: classifies a byte and emits up to two records.
`default_nettype none

module cst_lexer
    import cst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic     i_eoi,
    output t_lex_out      o_lex
);

    t_mode r_mode, n_mode;
    t_cnt  r_len, n_len;
    t_word r_win, n_win;
    t_cnt  r_tok_line, n_tok_line;
    t_cnt  r_tok_col, n_tok_col;
    t_cnt  r_cur_line, n_cur_line;
    t_cnt  r_cur_col, n_cur_col;

    logic  s_e0;
    t_kind s_k0;
    t_cnt  s_l0;
    logic  s_e1;
    t_kind s_k1;

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_ident(logic [7:0] b);
        return (b == CH_UNDER) || is_alpha(b) || is_digit(b);
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == " ") || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_op(logic [7:0] b);
        logic r;
        case (b)
            "+", ".", "=", "-", "/", "%", "*", "(", ")", "[",
            "]", "{", "}", ">", "<", "&", "|", "~", "!", "^": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_punct(logic [7:0] b);
        logic r;
        case (b)
            ";", ",", "\"", "'", ":": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Record of a pending token comes first, then a token started by this byte.
    always_comb begin : next_state
        logic done;
        done       = 1'b0;
        n_mode     = r_mode;
        n_len      = r_len;
        n_win      = r_win;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        s_e0       = 1'b0;
        s_k0       = K_IGNORE;
        s_l0       = '0;
        s_e1       = 1'b0;
        s_k1       = K_IGNORE;

        // resolve a held slash or quote
        case (r_mode)
            M_HOLD_SLASH: begin
                if (i_byte == CH_SLASH || i_byte == CH_STAR) begin
                    n_mode = M_COMMENT;
                    n_len  = t_cnt'(2);
                    done   = 1'b1;
                    if (i_eoi) begin
                        s_e0 = 1'b1;
                        s_k0 = K_END;
                        s_l0 = t_cnt'(2);
                    end
                end else begin
                    s_e0   = 1'b1;
                    s_k0   = K_OPERATOR;
                    s_l0   = t_cnt'(1);
                    n_mode = M_IDLE;
                    n_len  = '0;
                end
            end
            M_HOLD_QUOTE: begin
                if (!i_byte[7]) begin
                    n_mode = M_LITERAL;
                    n_len  = t_cnt'(1);
                end else begin
                    s_e0   = 1'b1;
                    s_k0   = K_PUNCT;
                    s_l0   = t_cnt'(1);
                    n_mode = M_IDLE;
                    n_len  = '0;
                end
            end
            default: ;
        endcase

        // continue or close a running token
        if (!done) begin
            case (n_mode)
                M_LITERAL: begin
                    n_len = sat_inc(n_len);
                    done  = 1'b1;
                    if (i_byte == CH_QUOTE || i_eoi) begin
                        s_e0   = 1'b1;
                        s_k0   = (i_eoi) ? K_END : K_LITERAL;
                        s_l0   = n_len;
                        n_mode = M_IDLE;
                        n_len  = '0;
                    end
                end
                M_COMMENT: begin
                    done = 1'b1;
                    if (i_byte == CH_NL) begin
                        s_e0   = 1'b1;
                        s_k0   = (i_eoi) ? K_END : K_COMMENT;
                        s_l0   = n_len;
                        n_mode = M_IDLE;
                        n_len  = '0;
                    end else begin
                        n_len = sat_inc(n_len);
                        if (i_eoi) begin
                            s_e0 = 1'b1;
                            s_k0 = K_END;
                            s_l0 = n_len;
                        end
                    end
                end
                M_IDENT: begin
                    if (is_ident(i_byte)) begin
                        done = 1'b1;
                        if (n_len < t_cnt'(KW_BYTES)) begin
                            n_win = {n_win[KW_BYTES*8-9:0], i_byte};
                        end
                        n_len = sat_inc(n_len);
                        if (i_eoi) begin
                            s_e0 = 1'b1;
                            s_k0 = kw_match(n_win, n_len) ? K_KEYWORD : K_IDENT;
                            s_l0 = n_len;
                        end
                    end else begin
                        s_e0   = 1'b1;
                        s_k0   = kw_match(n_win, n_len) ? K_KEYWORD : K_IDENT;
                        s_l0   = n_len;
                        n_mode = M_IDLE;
                        n_len  = '0;
                    end
                end
                M_SPACE: begin
                    if (is_space(i_byte)) begin
                        done  = 1'b1;
                        n_len = sat_inc(n_len);
                        if (i_eoi) begin
                            s_e0 = 1'b1;
                            s_k0 = K_END;
                            s_l0 = n_len;
                        end
                    end else begin
                        s_e0   = 1'b1;
                        s_k0   = K_IGNORE;
                        s_l0   = n_len;
                        n_mode = M_IDLE;
                        n_len  = '0;
                    end
                end
                default: ;
            endcase
        end

        // start a new token at the current position
        if (!done) begin
            n_tok_line = r_cur_line;
            n_tok_col  = r_cur_col;
            n_len      = '0;
            if (i_byte == CH_HASH) begin
                s_e1 = 1'b1;
                s_k1 = K_DIRECTIVE;
            end else if (i_byte == CH_QUOTE) begin
                if (i_eoi) begin
                    s_e1 = 1'b1;
                    s_k1 = K_END;
                end else begin
                    n_mode = M_HOLD_QUOTE;
                end
            end else if (i_byte == CH_SLASH) begin
                if (i_eoi) begin
                    s_e1 = 1'b1;
                    s_k1 = K_OPERATOR;
                end else begin
                    n_mode = M_HOLD_SLASH;
                end
            end else if (is_op(i_byte)) begin
                s_e1 = 1'b1;
                s_k1 = K_OPERATOR;
            end else if (is_punct(i_byte)) begin
                s_e1 = 1'b1;
                s_k1 = K_PUNCT;
            end else if (is_digit(i_byte)) begin
                s_e1 = 1'b1;
                s_k1 = K_NUMBER;
            end else if (is_ident(i_byte)) begin
                n_win  = t_word'(i_byte);
                n_len  = t_cnt'(1);
                n_mode = M_IDENT;
                if (i_eoi) begin
                    s_e1 = 1'b1;
                    s_k1 = kw_match(n_win, n_len) ? K_KEYWORD : K_IDENT;
                end
            end else if (is_space(i_byte)) begin
                n_len  = t_cnt'(1);
                n_mode = M_SPACE;
                if (i_eoi) begin
                    s_e1 = 1'b1;
                    s_k1 = K_END;
                end
            end else begin
                s_e1 = 1'b1;
                s_k1 = (i_eoi) ? K_END : K_IGNORE;
            end
        end

        // advance the position, restart it after the final byte
        if (i_eoi) begin
            n_cur_line = '0;
            n_cur_col  = '0;
            n_mode     = M_IDLE;
            n_len      = '0;
        end else if (i_byte == CH_NL) begin
            n_cur_line = sat_inc(r_cur_line);
            n_cur_col  = '0;
        end else begin
            n_cur_col = sat_inc(r_cur_col);
        end
    end

    always_comb begin : outputs
        o_lex.v0      = i_step && s_e0;
        o_lex.r0.kind = s_k0;
        o_lex.r0.line = clamp_out(r_tok_line);
        o_lex.r0.col  = clamp_out(r_tok_col);
        o_lex.r0.len  = clamp_out(s_l0);
        o_lex.r0.last = !s_e1;
        o_lex.v1      = i_step && s_e1;
        o_lex.r1.kind = s_k1;
        o_lex.r1.line = clamp_out(r_cur_line);
        o_lex.r1.col  = clamp_out(r_cur_col);
        o_lex.r1.len  = OUT_W'(1);
        o_lex.r1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_len      <= '0;
            r_win      <= '0;
            r_tok_line <= '0;
            r_tok_col  <= '0;
            r_cur_line <= '0;
            r_cur_col  <= '0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_len      <= n_len;
            r_win      <= n_win;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_cur_line <= n_cur_line;
            r_cur_col  <= n_cur_col;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cst_outq.sv
// Record queue: takes up to two records a cycle, hands out one per request.
`default_nettype none

module cst_outq
    import cst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_lex_out i_push,
    input  wire logic     i_stall,
    output logic          o_valid,
    output t_rec          o_rec,
    output logic          o_room
);

    t_rec                  r_q [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_head, n_head;
    logic [OUTQ_PTR_W:0]   r_count, n_count;
    logic [OUTQ_PTR_W-1:0] tail_a, tail_b;
    logic [OUTQ_PTR_W:0]   n_pushed;
    logic                  pop;
    logic                  wr_a, wr_b;
    t_rec                  data_a;

    assign o_valid = (r_count != '0);
    assign o_rec   = r_q[r_head];
    // room for two records, judged on the registered fill only
    assign o_room  = (r_count <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - 2));
    assign pop     = o_valid && !i_stall;

    assign wr_a   = i_push.v0 || i_push.v1;
    assign wr_b   = i_push.v0 && i_push.v1;
    assign data_a = (i_push.v0) ? i_push.r0 : i_push.r1;
    assign tail_a = r_head + r_count[OUTQ_PTR_W-1:0];
    assign tail_b = tail_a + OUTQ_PTR_W'(1);

    assign n_pushed = (OUTQ_PTR_W+1)'(i_push.v0) + (OUTQ_PTR_W+1)'(i_push.v1);
    assign n_count  = r_count + n_pushed - (OUTQ_PTR_W+1)'(pop);
    assign n_head   = r_head + OUTQ_PTR_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_q[tail_a] <= data_a;
        end
        if (wr_b) begin
            r_q[tail_b] <= i_push.r1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/c_source_tokenizer.sv
// Top level of the C source tokenizer: input register, lexer step, record queue.
//
// Input channel: one source byte per request (i_byte_in, i_end_of_input) on
// i_valid / o_stall. Output channel: one token record per request on
// o_valid / i_stall; o_last_of_run marks the final record caused by a byte.
// A byte is registered on acceptance in the input register, stepped through
// the lexer once the record queue has room, and its records are written into
// the queue, whose head drives o_valid. One byte is consumed per cycle while
// the queue has room; a byte that closes a pending token and also forms a
// token of its own gives two records, and the output hands them out one per
// request. Keyword matching is a row of parallel comparators on an 8-byte
// word register.
// The lexer steps a byte only while the four-entry record queue has room
// for two records; otherwise o_stall rises with the byte held in the input
// register. A stalled receiver keeps the head record steady and, once the
// queue fills, backs up into o_stall. Reset is synchronous and active low:
// it empties the queue and the input register and returns the position
// counters and the scan state to zero and idle.
`default_nettype none

module c_source_tokenizer
    import cst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_end_of_input,
    output logic             o_stall,
    output logic             o_valid,
    output logic [3:0]       o_token_kind,
    output logic [15:0]      o_start_line,
    output logic [15:0]      o_start_column,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_run,
    input  wire logic        i_stall
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic       accept;
    logic       step;
    logic       room;
    t_lex_out   lex;
    t_rec       head;

    assign step       = r_in_valid && room;
    assign o_stall    = r_in_valid && !room;
    assign accept     = i_valid && !o_stall;
    assign n_in_valid = accept || (r_in_valid && !step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // hold the byte while it waits for queue room
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte_in;
            r_in_eoi  <= i_end_of_input;
        end
    end

    cst_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_lex   (lex)
    );

    cst_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (lex),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_rec   (head),
        .o_room  (room)
    );

    assign o_token_kind   = head.kind;
    assign o_start_line   = head.line;
    assign o_start_column = head.col;
    assign o_token_length = head.len;
    assign o_last_of_run  = head.last;

endmodule

`default_nettype wire

FILE: rtl/cst_checker.sv
// Port-level checks on the C source tokenizer, bound to the top level.
`default_nettype none

module cst_checker
    import cst_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic [3:0]  o_token_kind,
    input wire logic [15:0] o_start_line,
    input wire logic [15:0] o_start_column,
    input wire logic [15:0] o_token_length,
    input wire logic        o_last_of_run,
    input wire logic        i_stall
);

    // a stalled record stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
            $stable(o_start_line) && $stable(o_start_column) &&
            $stable(o_token_length) && $stable(o_last_of_run))
        else $error("stalled record changed");

    // reset leaves nothing pending on either side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("queue or input register not cleared by reset");

    // an end record is always the last one of its byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == K_END) |-> o_last_of_run)
        else $error("end record not last of run");

    a_single_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == K_DIRECTIVE || o_token_kind == K_OPERATOR ||
            o_token_kind == K_PUNCT || o_token_kind == K_NUMBER)
        |-> (o_token_length == 16'd1))
        else $error("single-byte token with length other than one");

    a_keyword_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == K_KEYWORD)
        |-> (o_token_length >= 16'd2) && (o_token_length <= 16'(KW_BYTES)))
        else $error("keyword length out of range");

endmodule

bind c_source_tokenizer cst_checker u_cst_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the C source tokenizer with its own lexer model.
`default_nettype none

module tb;
    import cst_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } t_src_req;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_byte_in      = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [15:0] o_start_line;
    logic [15:0] o_start_column;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    t_src_req src_bytes [$];
    t_rec     want_tokens [$];
    t_src_req next_req;
    t_rec     want_rec;

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    logic rx_hold     = 1'b0;
    int  hold_left    = 0;
    int  err_count    = 0;
    int  idle_cycles  = 0;
    int  queued_total = 0;

    // Lexer model state
    t_mode      lx_mode     = M_IDLE;
    t_cnt       lx_run      = '0;
    t_cnt       lx_tok_line = '0;
    t_cnt       lx_tok_col  = '0;
    t_cnt       lx_line     = '0;
    t_cnt       lx_col      = '0;
    logic [7:0] word_bytes [0:KW_BYTES-1] = '{default: 8'h00};
    t_rec       staged_tok;
    logic       have_staged;

    string kw_names [0:28] = '{
        "char", "short", "int", "long", "unsigned", "signed", "float", "double",
        "bool", "_Bool", "struct", "enum", "union", "return", "while", "goto",
        "if", "do", "for", "typedef", "sizeof", "main", "const", "volatile",
        "extern", "static", "auto", "void", "else"};

    c_source_tokenizer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_byte_in      (i_byte_in),
        .i_end_of_input (i_end_of_input),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_token_kind   (o_token_kind),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run),
        .i_stall        (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_cnt bump(t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_numeral(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_word_char(logic [7:0] b);
        return b == CH_UNDER || is_letter(b) || is_numeral(b);
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_op_char(logic [7:0] b);
        case (b)
            "+", ".", "=", "-", "/", "%", "*", "(", ")", "[", "]", "{", "}",
            ">", "<", "&", "|", "~", "!", "^": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_punct_char(logic [7:0] b);
        case (b)
            ";", ",", "\"", "'", ":": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic word_is_reserved();
        logic hit;
        hit = 1'b0;
        if (lx_run <= KW_BYTES) begin
            for (int i = 0; i < 29; i++) begin
                if (kw_names[i].len() == lx_run) begin
                    logic same;
                    same = 1'b1;
                    for (int j = 0; j < kw_names[i].len(); j++)
                        if (kw_names[i][j] != word_bytes[j]) same = 1'b0;
                    if (same) hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // Stage one token so that the last one of a byte can be flagged.
    task automatic put_token(input t_kind kind, input t_cnt n);
        if (have_staged) want_tokens.push_back(staged_tok);
        staged_tok.kind = kind;
        staged_tok.line = lx_tok_line;
        staged_tok.col  = lx_tok_col;
        staged_tok.len  = n;
        staged_tok.last = 1'b0;
        have_staged = 1'b1;
        lx_mode = M_IDLE;
        lx_run  = '0;
    endtask

    task automatic put_word();
        put_token(word_is_reserved() ? K_KEYWORD : K_IDENT, lx_run);
    endtask

    task automatic add_word_char(input logic [7:0] b);
        if (lx_run < KW_BYTES) word_bytes[lx_run[$clog2(KW_BYTES)-1:0]] = b;
        lx_run = bump(lx_run);
    endtask

    task automatic lex_step(input logic [7:0] b, input logic eoi);
        logic done;
        done = 1'b0;
        have_staged = 1'b0;

        if (lx_mode == M_HOLD_SLASH) begin
            if (b == CH_SLASH || b == CH_STAR) begin
                lx_mode = M_COMMENT;
                lx_run  = t_cnt'(2);
                if (eoi) put_token(K_END, lx_run);
                done = 1'b1;
            end else begin
                put_token(K_OPERATOR, t_cnt'(1));
            end
        end else if (lx_mode == M_HOLD_QUOTE) begin
            if (b < 8'd128) begin
                lx_mode = M_LITERAL;
                lx_run  = t_cnt'(1);
            end else begin
                put_token(K_PUNCT, t_cnt'(1));
            end
        end

        if (!done && lx_mode == M_LITERAL) begin
            lx_run = bump(lx_run);
            if (b == CH_QUOTE) put_token(eoi ? K_END : K_LITERAL, lx_run);
            else if (eoi) put_token(K_END, lx_run);
            done = 1'b1;
        end else if (!done && lx_mode == M_COMMENT) begin
            if (b == CH_NL) begin
                put_token(eoi ? K_END : K_COMMENT, lx_run);
            end else begin
                lx_run = bump(lx_run);
                if (eoi) put_token(K_END, lx_run);
            end
            done = 1'b1;
        end else if (!done && lx_mode == M_IDENT) begin
            if (is_word_char(b)) begin
                add_word_char(b);
                if (eoi) put_word();
                done = 1'b1;
            end else begin
                put_word();
            end
        end else if (!done && lx_mode == M_SPACE) begin
            if (is_blank(b)) begin
                lx_run = bump(lx_run);
                if (eoi) put_token(K_END, lx_run);
                done = 1'b1;
            end else begin
                put_token(K_IGNORE, lx_run);
            end
        end

        if (!done) begin
            lx_tok_line = lx_line;
            lx_tok_col  = lx_col;
            lx_run      = '0;
            if (b == CH_HASH) begin
                put_token(K_DIRECTIVE, t_cnt'(1));
            end else if (b == CH_QUOTE) begin
                if (eoi) put_token(K_END, t_cnt'(1));
                else lx_mode = M_HOLD_QUOTE;
            end else if (b == CH_SLASH) begin
                if (eoi) put_token(K_OPERATOR, t_cnt'(1));
                else lx_mode = M_HOLD_SLASH;
            end else if (is_op_char(b)) begin
                put_token(K_OPERATOR, t_cnt'(1));
            end else if (is_punct_char(b)) begin
                put_token(K_PUNCT, t_cnt'(1));
            end else if (is_numeral(b)) begin
                put_token(K_NUMBER, t_cnt'(1));
            end else if (is_word_char(b)) begin
                add_word_char(b);
                lx_mode = M_IDENT;
                if (eoi) put_word();
            end else if (is_blank(b)) begin
                lx_run  = t_cnt'(1);
                lx_mode = M_SPACE;
                if (eoi) put_token(K_END, t_cnt'(1));
            end else begin
                put_token(eoi ? K_END : K_IGNORE, t_cnt'(1));
            end
        end

        // Restart positions after the end of a text.
        if (eoi) begin
            lx_line = '0;
            lx_col  = '0;
            lx_mode = M_IDLE;
            lx_run  = '0;
        end else if (b == CH_NL) begin
            lx_line = bump(lx_line);
            lx_col  = '0;
        end else begin
            lx_col = bump(lx_col);
        end

        if (have_staged) begin
            staged_tok.last = 1'b1;
            want_tokens.push_back(staged_tok);
        end
    endtask

    task automatic add_req(input logic [7:0] b, input logic eoi);
        t_src_req r;
        r.ch  = b;
        r.eoi = eoi;
        src_bytes.push_back(r);
        queued_total++;
    endtask

    // Random bytes end a text now and then.
    task automatic add_char(input logic [7:0] b);
        add_req(b, $urandom_range(39) == 0);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic logic [7:0] ascii_except(input logic [7:0] ban);
        logic [7:0] b;
        b = 8'($urandom_range(127));
        while (b == ban) b = 8'($urandom_range(127));
        return b;
    endfunction

    task automatic add_random_token();
        int n;
        case ($urandom_range(15))
            0, 1: add_text(kw_names[$urandom_range(28)]);
            2: begin
                add_text(kw_names[$urandom_range(28)]);
                add_char(pick("xs_9Q"));
            end
            3: add_text($urandom_range(1) ? "unisgned" : "unsigned");
            4: begin
                n = $urandom_range(11);
                add_char($urandom_range(3) == 0 ? CH_UNDER
                                                : 8'(8'h61 + $urandom_range(25)));
                for (int i = 0; i < n; i++)
                    add_char(pick(
                        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789"));
            end
            5: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) add_char(8'(8'h30 + $urandom_range(9)));
            end
            6: add_char(pick("+.=-%*()[]{}><&|~!^"));
            7: add_char(pick(";,':"));
            8: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) add_char(pick(" \t\n\r\v\f"));
            end
            9: begin
                add_char(CH_SLASH);
                add_char($urandom_range(1) ? CH_SLASH : CH_STAR);
                n = $urandom_range(8);
                for (int i = 0; i < n; i++) add_char(ascii_except(CH_NL));
                add_char(CH_NL);
            end
            10: begin
                add_char(CH_QUOTE);
                n = $urandom_range(6);
                for (int i = 0; i < n; i++) add_char(ascii_except(CH_QUOTE));
                add_char(CH_QUOTE);
            end
            11: add_char(CH_HASH);
            12: begin
                add_char(CH_QUOTE);
                add_char(8'(8'd128 + $urandom_range(127)));
            end
            13: begin
                add_char(CH_SLASH);
                add_char(ascii_except(CH_STAR));
            end
            14: add_char(CH_NL);
            default: add_char(8'($urandom_range(255)));
        endcase
    endtask

    task automatic wait_drained();
        while (src_bytes.size() != 0 || i_valid || want_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    // Source side: hold a stalled request, advance on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) lex_step(i_byte_in, i_end_of_input);
            if (!i_valid || !o_stall) begin
                if (src_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_req = src_bytes.pop_front();
                    i_valid        <= 1'b1;
                    i_byte_in      <= next_req.ch;
                    i_end_of_input <= next_req.eoi;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // Token side: compare each record with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (want_tokens.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected token kind %0d line %0d col %0d len %0d",
                             $time, o_token_kind, o_start_line, o_start_column,
                             o_token_length);
                end else begin
                    want_rec = want_tokens.pop_front();
                    check_field("token_kind", 16'(want_rec.kind), 16'(o_token_kind));
                    check_field("start_line", want_rec.line, o_start_line);
                    check_field("start_column", want_rec.col, o_start_column);
                    check_field("token_length", want_rec.len, o_token_length);
                    check_field("last_of_run", 16'(want_rec.last), 16'(o_last_of_run));
                end
            end
            // hold off for a counted stretch once asked to
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (rx_hold) begin
                i_stall   <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed text: every token class, lookahead cases, end-of-text cases.
        add_req(CH_HASH, 1'b0);
        add_req("i", 1'b0); add_req("n", 1'b0); add_req("t", 1'b0);
        add_req(" ", 1'b0); add_req("a", 1'b0); add_req("=", 1'b0);
        add_req(CH_QUOTE, 1'b0); add_req("q", 1'b0); add_req(CH_QUOTE, 1'b0);
        add_req(";", 1'b0);
        add_req(CH_SLASH, 1'b0); add_req(CH_SLASH, 1'b0); add_req("c", 1'b0);
        add_req(CH_NL, 1'b0);
        add_req(CH_SLASH, 1'b0); add_req("+", 1'b0); add_req("7", 1'b0);
        add_req(CH_QUOTE, 1'b0); add_req(8'h80, 1'b0);
        add_req(8'hFF, 1'b0); add_req(8'h00, 1'b1);
        add_req(CH_SLASH, 1'b1);
        add_req(CH_QUOTE, 1'b1);
        add_req("z", 1'b1);
        wait_drained();

        // Back-pressure: block the token side while requests keep coming.
        while (queued_total < 85) add_random_token();
        rx_hold <= 1'b1;
        @(posedge i_clk);
        rx_hold <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct <= 82; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct <= 0;  rx_stall_pct <= 82; end
                default: begin tx_idle_pct <= 33; rx_stall_pct <= 33; end
            endcase
            while (queued_total < 85 + 74 * (ph + 1)) add_random_token();
            wait_drained();
        end
        tx_idle_pct  <= 0;
        rx_stall_pct <= 0;

        repeat (12) @(posedge i_clk);
        if (want_tokens.size() != 0)
            $display("%0t: %0d predicted tokens never arrived", $time, want_tokens.size());
        if (err_count == 0 && want_tokens.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/cst_pkg.sv
rtl/cst_lexer.sv
rtl/cst_outq.sv
rtl/c_source_tokenizer.sv
rtl/cst_checker.sv
tb/tb.sv
